@@ rtl/smi_pkg.sv @@
// Shared constants and types for the small matrix inverse core.
// Used by smi_div and small_matrix_inverse_core.
package smi_pkg;

  localparam int unsigned FracBits = 16;
  localparam int unsigned WordBits = 32;
  localparam int unsigned NumElem  = 9;

  // Cofactor (up to 65 bits) and determinant (up to 98 bits) widths.
  localparam int unsigned CofBits  = 2 * WordBits + 1;
  localparam int unsigned DetBits  = 3 * WordBits + 2;
  localparam int unsigned NumBits  = CofBits + 2 * FracBits + 1;
  localparam int unsigned QuoBits  = NumBits;

  typedef logic signed [WordBits-1:0] word_t;
  typedef logic signed [CofBits-1:0]  cof_t;
  typedef logic signed [DetBits-1:0]  det_t;

  // Per-beat side information carried along the pipeline.
  typedef struct packed {
    logic valid;
    logic singular;
  } side_t;

endpackage

@@ rtl/smi_div.sv @@
// Pipelined restoring divider: one quotient bit per stage, for one element.
// Depends on smi_pkg. Gives round-to-nearest, saturated quotient.
module smi_div (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic signed [smi_pkg::CofBits-1:0]    cof_i,
  input  logic signed [smi_pkg::DetBits-1:0]    det_i,
  output logic signed [smi_pkg::WordBits-1:0]   quo_o,
  output logic                                  sat_o
);

  localparam int unsigned NB = smi_pkg::NumBits;
  localparam int unsigned DB = smi_pkg::DetBits + 1;
  localparam int unsigned RB = DB + 1;

  // stage registers: remainder, remaining numerator bits, quotient, denominator, sign, zero flag
  logic [RB-1:0] rem_q [NB+1];
  logic [NB-1:0] num_q [NB+1];
  logic [NB-1:0] quo_q [NB+1];
  logic [DB-1:0] den_q [NB+1];
  logic          neg_q [NB+1];
  logic          zero_q [NB+1];

  logic [smi_pkg::CofBits-1:0] mag_n;
  logic [smi_pkg::DetBits-1:0] mag_d;
  logic [NB-1:0]               num_d;

  // entry: magnitudes, numerator = 2*n*2^(2F) + d, denominator = 2d
  always_comb begin
    mag_n = cof_i[smi_pkg::CofBits-1] ? -cof_i : cof_i;
    mag_d = det_i[smi_pkg::DetBits-1] ? -det_i : det_i;
    num_d = ({{(NB-smi_pkg::CofBits){1'b0}}, mag_n} << (2 * smi_pkg::FracBits + 1))
          + NB'(mag_d);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= '0;
      num_q[0]  <= num_d;
      quo_q[0]  <= '0;
      den_q[0]  <= {mag_d, 1'b0};
      neg_q[0]  <= cof_i[smi_pkg::CofBits-1] ^ det_i[smi_pkg::DetBits-1];
      zero_q[0] <= (cof_i == '0);
    end
  end

  // one quotient bit per stage
  for (genvar s = 0; s < NB; s++) begin : g_stage
    logic [RB-1:0] sh;
    logic          ge;
    always_comb begin
      sh = {rem_q[s][RB-2:0], num_q[s][NB-1]};
      ge = sh >= RB'(den_q[s]);
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1]  <= ge ? sh - RB'(den_q[s]) : sh;
        num_q[s+1]  <= num_q[s] << 1;
        quo_q[s+1]  <= {quo_q[s][NB-2:0], ge};
        den_q[s+1]  <= den_q[s];
        neg_q[s+1]  <= neg_q[s];
        zero_q[s+1] <= zero_q[s];
      end
    end
  end

  // saturate and apply sign
  localparam logic [NB-1:0] LimPos = NB'((64'd1 << (smi_pkg::WordBits - 1)) - 64'd1);
  logic [NB-1:0] q, lim;
  logic          ovf;
  always_comb begin
    q     = quo_q[NB];
    lim   = LimPos + NB'(neg_q[NB]);
    ovf   = (q > lim) && !zero_q[NB];
    sat_o = ovf;
    if (zero_q[NB]) quo_o = '0;
    else if (ovf) quo_o = neg_q[NB] ? -smi_pkg::WordBits'(lim) : smi_pkg::WordBits'(lim);
    else quo_o = neg_q[NB] ? -smi_pkg::WordBits'(q) : smi_pkg::WordBits'(q);
  end

endmodule

@@ rtl/small_matrix_inverse_core.sv @@
// Small matrix inverse (2x2 or 3x3, signed Q16.16) by adjugate over determinant.
// Depends on smi_pkg and smi_div.
//
// Usage: present a matrix on the input channel with in_valid_i; a beat is
// taken on each edge where in_valid_i is high and in_stall_o is low. The
// result leaves on the output channel with out_valid_o, held while
// out_stall_i is high. matrix_size 3 selects 3x3, else 2x2 (upper-left).
// Pipeline: input register, 5 product/sum stages, one divider entry stage and
// 98 divider bit stages, then the output register. Throughput: one matrix per
// cycle while the output is not stalled; the divider depth, one quotient bit
// a stage, sets the latency. A stall of the output freezes the whole pipeline
// (in_stall_o follows out_stall_i when the output register is full), so
// no beat is lost or repeated. Reset clears all valid bits; data registers
// are not reset. Singular matrices give zero outputs with singular set.
module small_matrix_inverse_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  matrix_size_i,
  input  logic signed [31:0] a11_i, a12_i, a13_i, a21_i, a22_i, a23_i,
  input  logic signed [31:0] a31_i, a32_i, a33_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [31:0] inv11_o, inv12_o, inv13_o, inv21_o, inv22_o,
  output logic signed [31:0] inv23_o, inv31_o, inv32_o, inv33_o,
  output logic        singular_o,
  output logic        saturated_o
);

  localparam int unsigned W  = smi_pkg::WordBits;
  localparam int unsigned CB = smi_pkg::CofBits;
  localparam int unsigned DB = smi_pkg::DetBits;
  localparam int unsigned PB = 2 * W;
  localparam int unsigned PPB = CB;
  localparam int unsigned Lat = smi_pkg::NumBits + 1;

  logic en;
  assign en = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // stage 1: capture inputs
  smi_pkg::word_t e_q [9];
  logic           s3_q;
  logic           v1_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      e_q[0] <= a11_i; e_q[1] <= a12_i; e_q[2] <= a13_i;
      e_q[3] <= a21_i; e_q[4] <= a22_i; e_q[5] <= a23_i;
      e_q[6] <= a31_i; e_q[7] <= a32_i; e_q[8] <= a33_i;
      s3_q   <= (matrix_size_i == 2'd3);
    end
  end

  // stage 2: element products for cofactors
  logic signed [PB-1:0] p_q [9];
  logic signed [PB-1:0] r_q [9];
  smi_pkg::word_t       e2_q [9];
  logic                 s3b_q, v2_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q[0] <= e_q[4]*e_q[8]; r_q[0] <= e_q[5]*e_q[7];
      p_q[1] <= e_q[2]*e_q[7]; r_q[1] <= e_q[1]*e_q[8];
      p_q[2] <= e_q[1]*e_q[5]; r_q[2] <= e_q[2]*e_q[4];
      p_q[3] <= e_q[5]*e_q[6]; r_q[3] <= e_q[3]*e_q[8];
      p_q[4] <= e_q[0]*e_q[8]; r_q[4] <= e_q[2]*e_q[6];
      p_q[5] <= e_q[2]*e_q[3]; r_q[5] <= e_q[0]*e_q[5];
      p_q[6] <= e_q[3]*e_q[7]; r_q[6] <= e_q[4]*e_q[6];
      p_q[7] <= e_q[1]*e_q[6]; r_q[7] <= e_q[0]*e_q[7];
      p_q[8] <= e_q[0]*e_q[4]; r_q[8] <= e_q[1]*e_q[3];
      e2_q   <= e_q;
      s3b_q  <= s3_q;
    end
  end

  // stage 3: cofactors (size 2 takes elements directly)
  smi_pkg::cof_t  c_d [9];
  smi_pkg::cof_t  c_q [9];
  smi_pkg::word_t e3_q [3];
  logic           v3_q;
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      c_d[i] = s3b_q ? CB'(p_q[i]) - CB'(r_q[i]) : '0;
    end
    if (!s3b_q) begin
      c_d[0] = CB'(e2_q[4]);
      c_d[1] = -CB'(e2_q[1]);
      c_d[3] = -CB'(e2_q[3]);
      c_d[4] = CB'(e2_q[0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_q <= c_d;
      if (!s3b_q) begin
        // size 2 det = a11*cof0 + a12*cof3 with a13 term zeroed
        e3_q[0] <= e2_q[0];
        e3_q[1] <= e2_q[1];
        e3_q[2] <= '0;
      end else begin
        e3_q[0] <= e2_q[0];
        e3_q[1] <= e2_q[1];
        e3_q[2] <= e2_q[2];
      end
    end
  end

  // stage 4: first-row partial products, cofactor split into low and high halves
  logic signed [PPB-1:0] pl_q [3];
  logic signed [PPB-1:0] ph_q [3];
  smi_pkg::cof_t         c4_q [9];
  logic                  v4_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        pl_q[k] <= PPB'(e3_q[k]) * PPB'($signed({1'b0, c_q[3*k][W-1:0]}));
        ph_q[k] <= PPB'(e3_q[k]) * PPB'($signed(c_q[3*k][CB-1:W]));
      end
      c4_q <= c_q;
    end
  end

  // stage 5: recombine halves into full first-row terms
  logic signed [DB-1:0] t_q [3];
  smi_pkg::cof_t        c5_q [9];
  logic                 v5_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        t_q[k] <= (DB'(ph_q[k]) <<< W) + DB'(pl_q[k]);
      end
      c5_q <= c4_q;
    end
  end

  // stage 6: determinant sum
  smi_pkg::det_t det_q;
  smi_pkg::cof_t c6_q [9];
  logic          v6_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      det_q <= t_q[0] + t_q[1] + t_q[2];
      c6_q  <= c5_q;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0; v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i; v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q; v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  // dividers, one per element
  smi_pkg::word_t quo [9];
  logic [8:0]     sat;
  for (genvar i = 0; i < 9; i++) begin : g_div
    smi_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .cof_i (c6_q[i]),
      .det_i (det_q),
      .quo_o (quo[i]),
      .sat_o (sat[i])
    );
  end

  // side info delay line matching the divider depth
  smi_pkg::side_t side_q [Lat];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Lat; i++) side_q[i] <= '0;
    end else if (en) begin
      side_q[0] <= '{valid: v6_q, singular: (det_q == '0)};
      for (int i = 1; i < Lat; i++) side_q[i] <= side_q[i-1];
    end
  end

  // output register
  smi_pkg::word_t o_q [9];
  logic           sing_q, satf_q, ov_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en) begin
      ov_q <= side_q[Lat-1].valid;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      sing_q <= side_q[Lat-1].singular;
      satf_q <= !side_q[Lat-1].singular && (|sat);
      for (int i = 0; i < 9; i++) o_q[i] <= side_q[Lat-1].singular ? '0 : quo[i];
    end
  end

  assign out_valid_o = ov_q;
  assign singular_o  = sing_q;
  assign saturated_o = satf_q;
  assign inv11_o = o_q[0]; assign inv12_o = o_q[1]; assign inv13_o = o_q[2];
  assign inv21_o = o_q[3]; assign inv22_o = o_q[4]; assign inv23_o = o_q[5];
  assign inv31_o = o_q[6]; assign inv32_o = o_q[7]; assign inv33_o = o_q[8];

  // a singular result carries no saturation and zero inv11 and inv22 elements
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && singular_o |-> !saturated_o && inv11_o == '0 && inv22_o == '0)
    else $error("singular result not cleared");
  // pipeline holds while output stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(inv11_o) && $stable(singular_o))
    else $error("output changed under stall");
  // input stall only when output full and stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("spurious input stall");

endmodule
